// ===== rtl/core/imu_sample_conditioner_top_macros.svh =====
// Assertion macros for the port checker of the IMU sample conditioner.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef IMU_SAMPLE_CONDITIONER_TOP_MACROS_SVH
`define IMU_SAMPLE_CONDITIONER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMUSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMUSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/imusc_pkg.sv =====
// Package for the IMU sample conditioner: beat types, configuration types and codes.
// No dependencies; every module file of the block imports it.
`timescale 1ns / 1ps

package imusc_pkg;

    localparam int NUM_AXES = 3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ACCEL_RANGE = 3'd0;
    localparam logic [2:0] CFG_GYRO_RANGE  = 3'd1;
    localparam logic [2:0] CFG_ORIENT      = 3'd2;
    localparam logic [2:0] CFG_GAIN_POS    = 3'd3;
    localparam logic [2:0] CFG_GAIN_NEG    = 3'd4;
    localparam logic [2:0] CFG_GYRO_BIAS   = 3'd5;

    // Orientation modes; the unused code behaves as native.
    localparam logic [1:0] ORIENT_NATIVE  = 2'd0;
    localparam logic [1:0] ORIENT_SWAP_XY = 2'd1;
    localparam logic [1:0] ORIENT_ROTATE  = 2'd2;

    localparam logic [47:0] GAIN_RESET = 48'h4000_4000_4000;

    // 250*pi/90 in Q20, rounded to nearest.
    localparam logic signed [24:0] GYRO_K_Q20 = 25'sd9150552;

    typedef struct packed {
        logic       command;
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
        logic [7:0] z_high_byte;
        logic [7:0] z_low_byte;
    } in_beat_t;

    typedef struct packed {
        logic               sensor_kind;
        logic signed [23:0] axis_x_out;
        logic signed [23:0] axis_y_out;
        logic signed [23:0] axis_z_out;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]  accel_range_code;
        logic [1:0]  gyro_range_code;
        logic [1:0]  orientation_mode;
        logic [47:0] accel_gain_positive;
        logic [47:0] accel_gain_negative;
        logic [47:0] gyro_bias_packed;
    } cfg_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } lane_ctl_t;

endpackage

// ===== rtl/core/imu_sample_conditioner_top.sv =====
// IMU sample conditioner: takes one beat per clock while the output is taken, and
// returns one result beat for each accepted beat. Its registers are the lane multiply
// stage, the lane rounding stage and the output register of the merging stage; each
// axis has its own 19 x 25 bit multiplier, so the throughput is one beat per cycle
// whenever the output is taken. Each stage moves on when the one after it is empty or
// moving, so bubbles close up and in_ready only drops while the output beat and both
// stages are held. The configuration port is always ready, and there is no clearing
// pass after reset. Depends on imusc_pkg, imusc_cfg, imusc_lane and imusc_merge.
`timescale 1ns / 1ps

module imu_sample_conditioner_top
    import imusc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    cfg_t      cfg;
    lane_ctl_t ctl;
    logic      adv_out;

    logic a_valid_reg;
    logic a_valid_next;
    logic b_valid_reg;
    logic b_valid_next;
    logic kind_a_reg;
    logic kind_b_reg;

    logic [15:0]        raw [NUM_AXES];
    logic signed [23:0] lane_value [NUM_AXES];

    assign cfg_ready = 1'b1;

    imusc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb
    begin
        adv_out      = !out_valid || out_ready;
        ctl.adv_b    = !b_valid_reg || adv_out;
        ctl.adv_a    = !a_valid_reg || ctl.adv_b;
        a_valid_next = ctl.adv_a ? in_valid : a_valid_reg;
        b_valid_next = ctl.adv_b ? a_valid_reg : b_valid_reg;
    end

    assign in_ready = ctl.adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_a)
        begin
            kind_a_reg <= in_data.command;
        end
        if (ctl.adv_b)
        begin
            kind_b_reg <= kind_a_reg;
        end
    end

    assign raw[0] = {in_data.x_high_byte, in_data.x_low_byte};
    assign raw[1] = {in_data.y_high_byte, in_data.y_low_byte};
    assign raw[2] = {in_data.z_high_byte, in_data.z_low_byte};

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        imusc_lane u_lane (
            .clk         (clk),
            .ctl         (ctl),
            .gyro        (in_data.command),
            .raw         (raw[a]),
            .accel_shift (cfg.accel_range_code),
            .gyro_shift  (cfg.gyro_range_code),
            .gain_pos    (cfg.accel_gain_positive[16*a +: 16]),
            .gain_neg    (cfg.accel_gain_negative[16*a +: 16]),
            .bias        (cfg.gyro_bias_packed[16*a +: 16]),
            .value       (lane_value[a])
        );
    end

    imusc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv_out),
        .lane_valid (b_valid_reg),
        .kind       (kind_b_reg),
        .vx         (lane_value[0]),
        .vy         (lane_value[1]),
        .vz         (lane_value[2]),
        .mode       (cfg.orientation_mode),
        .beat_valid (out_valid),
        .beat       (out_data)
    );

endmodule

// ===== rtl/core/imusc_cfg.sv =====
// Configuration register file of the IMU sample conditioner.
// Depends on imusc_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module imusc_cfg
    import imusc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [47:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ACCEL_RANGE: cfg_next.accel_range_code    = wr_data[1:0];
                CFG_GYRO_RANGE:  cfg_next.gyro_range_code     = wr_data[1:0];
                CFG_ORIENT:      cfg_next.orientation_mode    = wr_data[1:0];
                CFG_GAIN_POS:    cfg_next.accel_gain_positive = wr_data;
                CFG_GAIN_NEG:    cfg_next.accel_gain_negative = wr_data;
                CFG_GYRO_BIAS:   cfg_next.gyro_bias_packed    = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_range_code    <= 2'd1;
            cfg_reg.gyro_range_code     <= 2'd1;
            cfg_reg.orientation_mode    <= ORIENT_NATIVE;
            cfg_reg.accel_gain_positive <= GAIN_RESET;
            cfg_reg.accel_gain_negative <= GAIN_RESET;
            cfg_reg.gyro_bias_packed    <= 48'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/imusc_lane.sv =====
// One axis lane: range shift, gain or rad/s multiply, rounding and bias removal.
// Depends on imusc_pkg for the lane control bundle and the gyro constant.
`timescale 1ns / 1ps

module imusc_lane
    import imusc_pkg::*;
(
    input  logic               clk,
    input  lane_ctl_t          ctl,
    input  logic               gyro,
    input  logic [15:0]        raw,
    input  logic [1:0]         accel_shift,
    input  logic [1:0]         gyro_shift,
    input  logic [15:0]        gain_pos,
    input  logic [15:0]        gain_neg,
    input  logic [15:0]        bias,
    output logic signed [23:0] value
);

    localparam logic signed [43:0] ROUND_ACCEL = 44'sd1 <<< 13;
    localparam logic signed [43:0] ROUND_GYRO  = 44'sd1 <<< 19;

    logic [1:0]         shamt;
    logic signed [18:0] scaled;
    logic               positive;
    logic signed [24:0] coef;

    logic signed [43:0] prod_reg;
    logic signed [43:0] prod_next;
    logic               gyro_b_reg;
    logic [15:0]        bias_b_reg;

    logic signed [43:0] rounded;
    logic signed [23:0] bias_ext;
    logic signed [23:0] value_reg;
    logic signed [23:0] value_next;

    // Stage A: scale by the full-scale range and multiply.
    always_comb
    begin
        shamt    = gyro ? gyro_shift : accel_shift;
        scaled   = $signed({{3{raw[15]}}, raw}) <<< shamt;
        // A zero axis value takes the negative gain, as any non-positive one does.
        positive = !scaled[18] && (scaled != 19'sd0);
        coef     = gyro ? GYRO_K_Q20
                        : $signed({9'd0, (positive ? gain_pos : gain_neg)});
        prod_next = scaled * coef;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_a)
        begin
            prod_reg   <= prod_next;
            gyro_b_reg <= gyro;
            bias_b_reg <= bias;
        end
    end

    // Stage B: round half up and take the floor; gyro also drops its bias.
    always_comb
    begin
        rounded  = prod_reg + (gyro_b_reg ? ROUND_GYRO : ROUND_ACCEL);
        bias_ext = $signed({{8{bias_b_reg[15]}}, bias_b_reg});
        value_next = gyro_b_reg ? (rounded[43:20] - bias_ext) : rounded[37:14];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_b)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/imusc_merge.sv =====
// Merging stage: remaps the three lane results by orientation and holds the output beat.
// Depends on imusc_pkg for the output beat type and the orientation codes.
`timescale 1ns / 1ps

module imusc_merge
    import imusc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               lane_valid,
    input  logic               kind,
    input  logic signed [23:0] vx,
    input  logic signed [23:0] vy,
    input  logic signed [23:0] vz,
    input  logic [1:0]         mode,
    output logic               beat_valid,
    output out_beat_t          beat
);

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;
    out_beat_t beat_next;

    always_comb
    begin
        beat_next.sensor_kind = kind;
        case (mode)
            ORIENT_SWAP_XY:
            begin
                beat_next.axis_x_out = vy;
                beat_next.axis_y_out = vx;
                beat_next.axis_z_out = -vz;
            end
            ORIENT_ROTATE:
            begin
                beat_next.axis_x_out = vy;
                beat_next.axis_y_out = -vz;
                beat_next.axis_z_out = -vx;
            end
            default:
            begin
                beat_next.axis_x_out = vx;
                beat_next.axis_y_out = vy;
                beat_next.axis_z_out = vz;
            end
        endcase
        valid_next = adv ? lane_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== rtl/core/imusc_checker.sv =====
// Port-level checker for the IMU sample conditioner, bound to the top level.
// Depends on imusc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "imu_sample_conditioner_top_macros.svh"

module imusc_port_checker
    import imusc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input out_beat_t   out_data,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A held output beat keeps its payload.
    `IMUSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

    // The input only stalls when the output beat is blocked.
    `IMUSC_ASSERT_IMP(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output back-pressure")

    // With the output taken freely, an accepted beat comes out through both lane stages and the output register.
    `IMUSC_ASSERT_NEXT(a_latency, (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready, out_valid, "accepted beat did not reach the output")

    // Configuration writes are never held off.
    `IMUSC_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind imu_sample_conditioner_top imusc_port_checker u_imusc_checker (.*);

// ===== sim/imusc_checker.sv =====
// Scoreboard for the IMU sample conditioner: watches the sample, result and register
// channels, predicts every result from its own copy of the registers and compares.
// Depends on imusc_pkg; also holds the small package of command codes the bench shares.
`timescale 1ns / 1ps

package imusc_tb_pkg;

    localparam logic CMD_ACCEL = 1'b0;
    localparam logic CMD_GYRO  = 1'b1;

endpackage

module imusc_checker
    import imusc_pkg::*;
    import imusc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_beat_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_beat_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          mismatch_count,
    output int          pending_count,
    output int          results_seen
);

    localparam int REPORT_LIMIT = 10;

    cfg_t      settings;
    out_beat_t expected_q[$];
    int        errors;
    int        checked;

    // Scale, correct and remap one raw sample under the given register settings.
    function automatic out_beat_t condition_sample(input cfg_t c, input in_beat_t b);
        logic [15:0] raw [3];
        logic [15:0] gain;
        longint      scaled;
        longint      corrected [3];
        longint      remapped [3];
        out_beat_t   r;
        raw[0] = {b.x_high_byte, b.x_low_byte};
        raw[1] = {b.y_high_byte, b.y_low_byte};
        raw[2] = {b.z_high_byte, b.z_low_byte};
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (b.command == CMD_GYRO)
            begin
                scaled = longint'($signed(raw[a])) <<< c.gyro_range_code;
                corrected[a] = ((scaled * longint'(GYRO_K_Q20) + (64'sd1 <<< 19)) >>> 20)
                               - longint'($signed(c.gyro_bias_packed[16 * a +: 16]));
            end
            else
            begin
                scaled = longint'($signed(raw[a])) <<< c.accel_range_code;
                // A zero axis takes the negative gain; it makes no difference to the value.
                gain = (scaled > 0) ? c.accel_gain_positive[16 * a +: 16]
                                    : c.accel_gain_negative[16 * a +: 16];
                corrected[a] = (scaled * longint'(gain) + 64'sd8192) >>> 14;
            end
        end
        case (c.orientation_mode)
            ORIENT_SWAP_XY:
            begin
                remapped[0] = corrected[1];
                remapped[1] = corrected[0];
                remapped[2] = -corrected[2];
            end
            ORIENT_ROTATE:
            begin
                remapped[0] = corrected[1];
                remapped[1] = -corrected[2];
                remapped[2] = -corrected[0];
            end
            default:
            begin
                remapped = corrected;
            end
        endcase
        r.sensor_kind = b.command;
        r.axis_x_out  = remapped[0][23:0];
        r.axis_y_out  = remapped[1][23:0];
        r.axis_z_out  = remapped[2][23:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            settings.accel_range_code    = 2'd1;
            settings.gyro_range_code     = 2'd1;
            settings.orientation_mode    = ORIENT_NATIVE;
            settings.accel_gain_positive = GAIN_RESET;
            settings.accel_gain_negative = GAIN_RESET;
            settings.gyro_bias_packed    = '0;
            expected_q.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("MISMATCH at %0t: result beat %0d arrived with none expected",
                                 $realtime, checked);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.sensor_kind !== want.sensor_kind ||
                        out_data.axis_x_out !== want.axis_x_out ||
                        out_data.axis_y_out !== want.axis_y_out ||
                        out_data.axis_z_out !== want.axis_z_out)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $write("MISMATCH at %0t beat %0d:", $realtime, checked);
                            $write(" expected kind %0d x %0d y %0d z %0d,", want.sensor_kind,
                                   want.axis_x_out, want.axis_y_out, want.axis_z_out);
                            $display(" got kind %0d x %0d y %0d z %0d", out_data.sensor_kind,
                                     out_data.axis_x_out, out_data.axis_y_out,
                                     out_data.axis_z_out);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(condition_sample(settings, in_data));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACCEL_RANGE: settings.accel_range_code    = cfg_data[1:0];
                    CFG_GYRO_RANGE:  settings.gyro_range_code     = cfg_data[1:0];
                    CFG_ORIENT:      settings.orientation_mode    = cfg_data[1:0];
                    CFG_GAIN_POS:    settings.accel_gain_positive = cfg_data;
                    CFG_GAIN_NEG:    settings.accel_gain_negative = cfg_data;
                    CFG_GYRO_BIAS:   settings.gyro_bias_packed    = cfg_data;
                    default:         ;
                endcase
            end
        end
        mismatch_count <= errors;
        pending_count  <= expected_q.size();
        results_seen   <= checked;
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the IMU sample conditioner: clock, reset, sample and register
// stimulus, output back-pressure, watchdog and verdict.
// Depends on imusc_pkg, imu_sample_conditioner_top and imusc_checker (with imusc_tb_pkg).
`timescale 1ns / 1ps

module tb;
    import imusc_pkg::*;
    import imusc_tb_pkg::*;

    localparam logic [2:0] CFG_SPARE_LO     = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI     = 3'd7;
    localparam int         RANDOM_PHASES    = 8;
    localparam int         ITEMS_PER_PHASE  = 150;
    localparam int         LONG_HOLD_CYCLES = 80;
    localparam int         DRAIN_CYCLES     = 8;
    localparam int         QUIET_LIMIT      = 2000;

    typedef enum logic [1:0] {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_beat_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_beat_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data  = '0;

    int mismatch_count;
    int pending_count;
    int results_seen;
    int send_gap_pct          = 0;
    int recv_stall_pct        = 0;
    int long_holds_requested  = 0;
    int accel_sent            = 0;
    int gyro_sent             = 0;
    int settings_loaded       = 0;
    int quiet_cycles          = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    imu_sample_conditioner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    imusc_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .results_seen   (results_seen)
    );

    function automatic in_beat_t make_sample(input logic cmd, input logic [15:0] x,
                                             input logic [15:0] y, input logic [15:0] z);
        in_beat_t s;
        s.command     = cmd;
        s.x_high_byte = x[15:8];
        s.x_low_byte  = x[7:0];
        s.y_high_byte = y[15:8];
        s.y_low_byte  = y[7:0];
        s.z_high_byte = z[15:8];
        s.z_low_byte  = z[7:0];
        return s;
    endfunction

    // Raw axis words lean toward the ends of the range and values around zero.
    function automatic logic [15:0] rand_axis();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_lane16();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h4000;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_traffic(input traffic_t t);
        case (t)
            TRAFFIC_STEADY:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            TRAFFIC_SENDER_GAPS:
            begin
                send_gap_pct   = 58;
                recv_stall_pct = 0;
            end
            TRAFFIC_RECEIVER_STALLS:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 58;
            end
            default:
            begin
                send_gap_pct   = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    task automatic offer(input in_beat_t s);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        if (s.command == CMD_GYRO)
            gyro_sent++;
        else
            accel_sent++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Registers may only change once every outstanding result beat has been taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_left;
        int long_holds_served;
        hold_left         = 0;
        long_holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (long_holds_served != long_holds_requested)
            begin
                long_holds_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] spare;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_traffic(TRAFFIC_STEADY);

        // Reset settings: zero axes, full-scale words on both sensors.
        settings_loaded++;
        offer(make_sample(CMD_ACCEL, 16'h0000, 16'h0000, 16'h0000));
        offer(make_sample(CMD_ACCEL, 16'h7FFF, 16'h8000, 16'h0001));
        offer(make_sample(CMD_ACCEL, 16'hFFFF, 16'h0000, 16'h8000));
        offer(make_sample(CMD_GYRO, 16'h7FFF, 16'h8000, 16'h0000));
        offer(make_sample(CMD_GYRO, 16'hFFFF, 16'h0001, 16'h0000));

        // Largest ranges, extreme gains and biases, and the unused orientation code.
        wait_for_drain();
        write_register(CFG_ACCEL_RANGE, 48'd3);
        write_register(CFG_GYRO_RANGE, 48'd3);
        write_register(CFG_ORIENT, 48'd3);
        write_register(CFG_GAIN_POS, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_GAIN_NEG, 48'h0000_0000_0000);
        write_register(CFG_GYRO_BIAS, 48'h8000_7FFF_8000);
        settings_loaded++;
        offer(make_sample(CMD_ACCEL, 16'h7FFF, 16'h8000, 16'h0000));
        offer(make_sample(CMD_ACCEL, 16'h0001, 16'hFFFF, 16'h7FFF));
        offer(make_sample(CMD_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF));
        offer(make_sample(CMD_GYRO, 16'h0000, 16'h0001, 16'h8000));

        // Smallest ranges and gains that put odd products exactly on a half LSB.
        wait_for_drain();
        write_register(CFG_ACCEL_RANGE, 48'd0);
        write_register(CFG_GYRO_RANGE, 48'd0);
        write_register(CFG_ORIENT, {46'd0, ORIENT_SWAP_XY});
        write_register(CFG_GAIN_POS, 48'h6000_2000_A000);
        write_register(CFG_GAIN_NEG, 48'hE000_2000_6000);
        write_register(CFG_GYRO_BIAS, 48'h0001_FFFF_0000);
        settings_loaded++;
        offer(make_sample(CMD_ACCEL, 16'h0001, 16'hFFFF, 16'h0003));
        offer(make_sample(CMD_ACCEL, 16'hFFFD, 16'h0005, 16'hFFFB));
        offer(make_sample(CMD_GYRO, 16'h1234, 16'hFEDC, 16'h0001));

        wait_for_drain();
        write_register(CFG_ORIENT, {46'd0, ORIENT_ROTATE});
        settings_loaded++;
        offer(make_sample(CMD_ACCEL, 16'h0101, 16'h8001, 16'h7F01));
        offer(make_sample(CMD_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF));

        // Writes past the last register must leave every setting alone.
        wait_for_drain();
        write_register(CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
        offer(make_sample(CMD_ACCEL, 16'h7FFF, 16'h8001, 16'h0002));
        offer(make_sample(CMD_GYRO, 16'hFFFF, 16'h0001, 16'h8000));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_drain();
            // Upper data bits of the narrow registers are junk that must be dropped.
            write_register(CFG_ACCEL_RANGE, {46'({$urandom, $urandom}), 2'(phase % 4)});
            write_register(CFG_GYRO_RANGE, {46'({$urandom, $urandom}), 2'(3 - phase % 4)});
            write_register(CFG_ORIENT, {46'({$urandom, $urandom}), 2'(phase % 4)});
            write_register(CFG_GAIN_POS, {pick_lane16(), pick_lane16(), pick_lane16()});
            write_register(CFG_GAIN_NEG, {pick_lane16(), pick_lane16(), pick_lane16()});
            write_register(CFG_GYRO_BIAS, {pick_lane16(), pick_lane16(), pick_lane16()});
            if ($urandom_range(1) != 0)
            begin
                spare = ($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
                write_register(spare, {16'($urandom), $urandom});
            end
            settings_loaded++;
            set_traffic(traffic_t'(phase % 4));
            // Hold the output off while samples keep coming so the pipeline fills.
            if (phase % 4 == 0)
                long_holds_requested++;
            repeat (ITEMS_PER_PHASE)
                offer(make_sample(($urandom_range(1) != 0) ? CMD_GYRO : CMD_ACCEL,
                                  rand_axis(), rand_axis(), rand_axis()));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d accel and %0d gyro samples, %0d result beats, %0d settings,",
                 accel_sent, gyro_sent, results_seen, settings_loaded);
        $display("Summary: all ranges and orientations, gain and bias extremes, long hold-off.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== imu_sample_conditioner_top.f =====
+incdir+rtl/core
rtl/core/imusc_pkg.sv
rtl/core/imusc_cfg.sv
rtl/core/imusc_lane.sv
rtl/core/imusc_merge.sv
rtl/core/imu_sample_conditioner_top.sv
rtl/core/imusc_checker.sv
sim/imusc_checker.sv
sim/tb.sv
